// ===== rtl/mnkw_pkg.sv =====
// Shared widths, types and constants for the Mitchell-Netravali kernel weight block.
package mnkw_pkg;

    // Field widths
    localparam int DIST_W   = 16;
    localparam int SHAPE_W  = 16;
    localparam int WEIGHT_W = 16;
    localparam int CFG_IDX_W = 1;

    // Fixed-point scales
    localparam int DIST_FRAC = 12;              // Q3.12 distance
    localparam int ONE_Q12   = 1 << DIST_FRAC;
    localparam int TWO_Q12   = 2 * ONE_Q12;
    localparam int ONE_Q14   = 1 << 14;

    // Reset value of both shape registers (one third in Q2.14)
    localparam logic [SHAPE_W-1:0] SHAPE_RESET = 16'd5461;

    // Datapath widths
    localparam int XW   = 13;   // |x| below two, Q12
    localparam int CW   = 25;   // coefficient working width
    localparam int K3W  = 21;   // cubic coefficient
    localparam int KW   = 23;   // other coefficients
    localparam int T1W  = 36;   // k3*x + k2*2^12
    localparam int MW   = 50;   // t1*x
    localparam int LOW_W = 24;  // low half of the split product
    localparam int THW  = 27;   // upper half plus k1
    localparam int PAW  = 41;   // upper partial product
    localparam int PBW  = 37;   // lower partial product
    localparam int SW   = 42;   // recombined sum
    localparam int CLW  = 19;   // clamped quotient numerator
    localparam int VW   = 18;   // offset numerator for the divide by three
    localparam int RPW  = 36;   // reciprocal product

    // Rounding and saturation: y = floor(total / 2^36) + 3, weight = floor(y / 6)
    localparam int ROUND_BIAS = 3;
    localparam int SAT_LIM    = 6 * 32768;      // |y| bound that keeps the weight in range
    localparam int HALF_SPAN  = SAT_LIM / 2;    // offset that makes y/2 non-negative
    localparam int RECIP3     = 174763;         // ceil(2^19 / 3)
    localparam int RECIP3_SH  = 19;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHAPE_B = 1'b0,
        REG_SHAPE_C = 1'b1
    } cfg_reg_t;

    // Polynomial coefficients for one word, scaled by 6 * 2^14
    typedef struct packed {
        logic signed [K3W-1:0] k3;
        logic signed [KW-1:0]  k2;
        logic signed [KW-1:0]  k1;
        logic signed [KW-1:0]  k0;
    } coef_t;

    // Per-stage load enables
    typedef struct packed {
        logic s6;
        logic s5;
        logic s4;
        logic s3;
        logic s2;
        logic s1;
    } stage_en_t;

endpackage

// ===== rtl/mnkw_if.sv =====
// Handshake channels of the kernel weight block: distance in, weight out, register writes.
interface mnkw_dist_if
    import mnkw_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DIST_W-1:0] distance;

    modport source (output valid, output distance, input ready);
    modport sink (input valid, input distance, output ready);
endinterface

interface mnkw_weight_if
    import mnkw_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [WEIGHT_W-1:0] weight;
    logic                       saturated;

    modport source (output valid, output weight, output saturated, input ready);
    modport sink (input valid, input weight, input saturated, output ready);
endinterface

interface mnkw_cfg_if
    import mnkw_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SHAPE_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/mnkw_coef.sv =====
// Stage 1: absolute distance, interval select and coefficient derivation.
module mnkw_coef
    import mnkw_pkg::*;
(
    input  logic                     clk,
    input  logic                     load,
    input  logic [SHAPE_W-1:0]       shape_b,
    input  logic [SHAPE_W-1:0]       shape_c,
    input  logic signed [DIST_W-1:0] distance,
    output logic [XW-1:0]            x,
    output coef_t                    coef
);

    logic [DIST_W-1:0]    abs_dist;
    logic signed [CW-1:0] bs;
    logic signed [CW-1:0] cs;
    logic signed [CW-1:0] p0, p2, p3;
    logic signed [CW-1:0] q0, q1, q2, q3;
    coef_t                coef_next;
    logic [XW-1:0]        x_reg;
    coef_t                coef_reg;

    // Fold the sign; the most negative code maps to eight, which lies beyond two
    assign abs_dist = distance[DIST_W-1] ? DIST_W'(-distance) : DIST_W'(distance);

    assign bs = $signed({{(CW-SHAPE_W){1'b0}}, shape_b});
    assign cs = $signed({{(CW-SHAPE_W){1'b0}}, shape_c});

    // Inner cubic, times six
    assign p0 = CW'(6 * ONE_Q14) - (bs * CW'(2));
    assign p2 = CW'(-18 * ONE_Q14) + (bs * CW'(12)) + (cs * CW'(6));
    assign p3 = CW'(12 * ONE_Q14) - (bs * CW'(9)) - (cs * CW'(6));

    // Outer cubic, times six
    assign q0 = (bs * CW'(8)) + (cs * CW'(24));
    assign q1 = -(bs * CW'(12)) - (cs * CW'(48));
    assign q2 = (bs * CW'(6)) + (cs * CW'(30));
    assign q3 = -bs - (cs * CW'(6));

    // Pick the polynomial; zero coefficients give a zero weight beyond two
    always_comb
    begin
        if (abs_dist < DIST_W'(ONE_Q12))
        begin
            coef_next.k3 = K3W'(p3);
            coef_next.k2 = KW'(p2);
            coef_next.k1 = '0;
            coef_next.k0 = KW'(p0);
        end
        else if (abs_dist < DIST_W'(TWO_Q12))
        begin
            coef_next.k3 = K3W'(q3);
            coef_next.k2 = KW'(q2);
            coef_next.k1 = KW'(q1);
            coef_next.k0 = KW'(q0);
        end
        else
        begin
            coef_next = '0;
        end
    end

    // Hold the word while the next stage is stalled
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg    <= abs_dist[XW-1:0];
            coef_reg <= coef_next;
        end
    end

    assign x    = x_reg;
    assign coef = coef_reg;

endmodule

// ===== rtl/mnkw_horner.sv =====
// Stages 2 to 4: Horner evaluation of the cubic, last product split in two halves.
module mnkw_horner
    import mnkw_pkg::*;
(
    input  logic                  clk,
    input  stage_en_t             en,
    input  logic [XW-1:0]         x,
    input  coef_t                 coef,
    output logic signed [PAW-1:0] pa,
    output logic [PBW-1:0]        pb,
    output logic signed [KW-1:0]  k0
);

    logic signed [XW:0]    xs1, xs2, xs3;
    logic signed [T1W-1:0] t1_next, t1_reg;
    logic [XW-1:0]         x2_reg, x3_reg;
    logic signed [KW-1:0]  k1_2_reg, k0_2_reg;
    logic signed [MW-1:0]  m_next, m_reg;
    logic signed [KW-1:0]  k1_3_reg, k0_3_reg;
    logic signed [THW-1:0] th;
    logic [LOW_W-1:0]      tl;
    logic signed [PAW-1:0] pa_next, pa_reg;
    logic [PBW-1:0]        pb_next, pb_reg;
    logic signed [KW-1:0]  k0_4_reg;

    assign xs1 = $signed({1'b0, x});
    assign xs2 = $signed({1'b0, x2_reg});
    assign xs3 = $signed({1'b0, x3_reg});

    // Stage 2: k3*x + k2*2^12
    assign t1_next = T1W'(coef.k3 * xs1) + (T1W'(coef.k2) <<< DIST_FRAC);

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            t1_reg   <= t1_next;
            x2_reg   <= x;
            k1_2_reg <= coef.k1;
            k0_2_reg <= coef.k0;
        end
    end

    // Stage 3: second Horner product
    assign m_next = MW'(t1_reg * xs2);

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            m_reg    <= m_next;
            x3_reg   <= x2_reg;
            k1_3_reg <= k1_2_reg;
            k0_3_reg <= k0_2_reg;
        end
    end

    // Stage 4: add k1*2^24 to the upper half, multiply both halves by x
    assign th      = THW'(m_reg >>> LOW_W) + THW'(k1_3_reg);
    assign tl      = m_reg[LOW_W-1:0];
    assign pa_next = PAW'(th * xs3);
    assign pb_next = PBW'(tl) * PBW'(x3_reg);

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            k0_4_reg <= k0_3_reg;
        end
    end

    assign pa = pa_reg;
    assign pb = pb_reg;
    assign k0 = k0_4_reg;

endmodule

// ===== rtl/mnkw_round.sv =====
// Stages 5 and 6: recombine, round, saturate and divide by six.
module mnkw_round
    import mnkw_pkg::*;
(
    input  logic                       clk,
    input  stage_en_t                  en,
    input  logic signed [PAW-1:0]      pa,
    input  logic [PBW-1:0]             pb,
    input  logic signed [KW-1:0]       k0,
    output logic signed [WEIGHT_W-1:0] weight,
    output logic                       saturated
);

    localparam logic signed [SW-1:0]  Y_MAX = SW'(SAT_LIM - 1);
    localparam logic signed [SW-1:0]  Y_MIN = SW'(-SAT_LIM);

    logic signed [SW-1:0]       pa_x, k0_x, pbh_x;
    logic signed [SW-1:0]       sum;
    logic signed [SW-1:0]       y;
    logic signed [CLW-1:0]      y_cl;
    logic                       sat_next;
    logic signed [CLW-1:0]      v_wide;
    logic [VW-1:0]              v_reg;
    logic                       sat5_reg;
    logic [RPW-1:0]             prod;
    logic [WEIGHT_W-1:0]        r;
    logic signed [WEIGHT_W-1:0] weight_reg;
    logic                       sat_reg;

    // Integer part of total / 2^36; the low product only carries into it
    assign pa_x  = SW'(pa);
    assign k0_x  = SW'(k0) <<< DIST_FRAC;
    assign pbh_x = $signed({{(SW-(PBW-LOW_W)){1'b0}}, pb[PBW-1:LOW_W]});
    assign sum   = pa_x + k0_x + pbh_x;
    assign y     = (sum >>> DIST_FRAC) + SW'(ROUND_BIAS);

    // Clip where y / 6 would leave the weight range
    always_comb
    begin
        if (y > Y_MAX)
        begin
            y_cl     = CLW'(Y_MAX);
            sat_next = 1'b1;
        end
        else if (y < Y_MIN)
        begin
            y_cl     = CLW'(Y_MIN);
            sat_next = 1'b1;
        end
        else
        begin
            y_cl     = CLW'(y);
            sat_next = 1'b0;
        end
    end

    // Halve and offset so the divide by three sees a non-negative value
    assign v_wide = (y_cl >>> 1) + CLW'(HALF_SPAN);

    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            v_reg    <= v_wide[VW-1:0];
            sat5_reg <= sat_next;
        end
    end

    // Divide by three with a reciprocal; remove the offset by flipping the top bit
    assign prod = RPW'(v_reg) * RPW'(RECIP3);
    assign r    = prod[RECIP3_SH+WEIGHT_W-1:RECIP3_SH];

    always_ff @(posedge clk)
    begin
        if (en.s6)
        begin
            weight_reg <= $signed({~r[WEIGHT_W-1], r[WEIGHT_W-2:0]});
            sat_reg    <= sat5_reg;
        end
    end

    assign weight    = weight_reg;
    assign saturated = sat_reg;

endmodule

// ===== rtl/mitchell_netravali_kernel_weight.sv =====
// Mitchell-Netravali kernel weight: six-stage pipeline, one distance word per cycle while dout is ready.
// An accepted distance word passes stages 1 to 6 in order and leaves as its weight word on dout.
// Throughput: one word per cycle while dout is ready; each stage holds independently, so din stays ready
// while earlier stages have room even if the output word is not taken.
// Reset: rst_n clears all stage valid bits and loads both shape registers with one third.
module mitchell_netravali_kernel_weight
    import mnkw_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    mnkw_cfg_if.sink      cfg,
    mnkw_dist_if.sink     din,
    mnkw_weight_if.source dout
);

    localparam int NUM_STAGES = 6;

    logic [SHAPE_W-1:0]    shape_b_reg;
    logic [SHAPE_W-1:0]    shape_c_reg;
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] load;
    stage_en_t             en;
    logic [XW-1:0]         x1;
    coef_t                 coef1;
    logic signed [PAW-1:0] pa4;
    logic [PBW-1:0]        pb4;
    logic signed [KW-1:0]  k0_4;

    // Shape registers: always ready, unknown indexes dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_b_reg <= SHAPE_RESET;
            shape_c_reg <= SHAPE_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_SHAPE_B: shape_b_reg <= cfg.data;
                REG_SHAPE_C: shape_c_reg <= cfg.data;
                default:     ;
            endcase
        end
    end

    // A stage loads when it is empty or its successor loads
    always_comb
    begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || dout.ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    assign en        = stage_en_t'(load);
    assign din.ready = load[0];

    // Advance valid bits with the data
    always_comb
    begin
        valid_next = valid_reg;
        if (load[0])
        begin
            valid_next[0] = din.valid;
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (load[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    mnkw_coef u_coef
    (
        .clk      (clk),
        .load     (en.s1),
        .shape_b  (shape_b_reg),
        .shape_c  (shape_c_reg),
        .distance (din.distance),
        .x        (x1),
        .coef     (coef1)
    );

    mnkw_horner u_horner
    (
        .clk  (clk),
        .en   (en),
        .x    (x1),
        .coef (coef1),
        .pa   (pa4),
        .pb   (pb4),
        .k0   (k0_4)
    );

    mnkw_round u_round
    (
        .clk       (clk),
        .en        (en),
        .pa        (pa4),
        .pb        (pb4),
        .k0        (k0_4),
        .weight    (dout.weight),
        .saturated (dout.saturated)
    );

    assign dout.valid = valid_reg[NUM_STAGES-1];

endmodule
